// ===== rtl/core/cod_pkg.sv =====
`default_nettype none

package cod_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int DZ_W       = 24;
  localparam int WARMUP_W   = 16;
  localparam int STEP_W     = 24;
  localparam int CORR_W     = 25;
  localparam int COUNT_W    = 16;

  localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 17'h10000;
  localparam logic [ALPHA_FRAC:0] ROUND_HALF = 17'h08000;

  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 17'd6554;
  localparam logic [DZ_W-1:0]     DZ_RST     = 24'd32768;
  localparam logic [WARMUP_W-1:0] WARMUP_RST = 16'd4;
  localparam logic [STEP_W-1:0]   STEP_RST   = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 2'd0,
    REG_DEAD_ZONE = 2'd1,
    REG_WARMUP    = 2'd2,
    REG_MAX_STEP  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha;
    logic [DZ_W-1:0]     dead_zone;
    logic [WARMUP_W-1:0] warmup;
    logic [STEP_W-1:0]   max_step;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/clock_offset_drift_corrector.sv =====
// path: an accepted request is held in the cod_diff stage register, then in the cod_avg result register
// throughput: one request per cycle while out_ready_i is high; the averaging register closes its loop on itself
// the stage register can take one new request while a finished result waits for
// out_ready_i; once both registers hold data, in_ready_o stays low until out_ready_i
// reset: asynchronous, active low; clears average, sample count and valids,
// and loads the configuration registers with their defaults
`default_nettype none

module clock_offset_drift_corrector #(
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire  [cod_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [cod_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire  [TICK_BITS-1:0]                   reference_tick_i,
  input  wire  [TICK_BITS-1:0]                   local_tick_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [cod_pkg::CORR_W-1:0]      correction_o,
  output logic                                   correction_active_o,
  output logic signed [TICK_BITS+FRAC_BITS-1:0]  smoothed_offset_o
);

  import cod_pkg::*;

  cfg_t                           cfg_q;
  logic                           s1_valid, s1_ready;
  logic [TICK_BITS+FRAC_BITS-1:0] s1_raw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= ALPHA_RST;
      cfg_q.dead_zone <= DZ_RST;
      cfg_q.warmup    <= WARMUP_RST;
      cfg_q.max_step  <= STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ALPHA: begin
          cfg_q.alpha <= cfg_data_i[ALPHA_W-1:0];
        end
        REG_DEAD_ZONE: begin
          cfg_q.dead_zone <= cfg_data_i[DZ_W-1:0];
        end
        REG_WARMUP: begin
          cfg_q.warmup <= cfg_data_i[WARMUP_W-1:0];
        end
        REG_MAX_STEP: begin
          cfg_q.max_step <= cfg_data_i[STEP_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  cod_diff #(
    .TICK_BITS (TICK_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_diff (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .reference_tick_i (reference_tick_i),
    .local_tick_i     (local_tick_i),
    .valid_o          (s1_valid),
    .ready_i          (s1_ready),
    .raw_o            (s1_raw)
  );

  cod_avg #(
    .TICK_BITS (TICK_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_avg (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .valid_i             (s1_valid),
    .ready_o             (s1_ready),
    .raw_i               (s1_raw),
    .valid_o             (out_valid_o),
    .ready_i             (out_ready_i),
    .correction_o        (correction_o),
    .correction_active_o (correction_active_o),
    .smoothed_offset_o   (smoothed_offset_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cod_diff.sv =====
`default_nettype none

module cod_diff #(
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            valid_i,
  output logic                           ready_o,
  input  wire  [TICK_BITS-1:0]           reference_tick_i,
  input  wire  [TICK_BITS-1:0]           local_tick_i,
  output logic                           valid_o,
  input  wire                            ready_i,
  output logic [TICK_BITS+FRAC_BITS-1:0] raw_o
);

  logic [TICK_BITS:0]                diff;
  logic [TICK_BITS-1:0]              sat;
  logic [TICK_BITS+FRAC_BITS-1:0]    raw_d, raw_q;
  logic                              vld_d, vld_q;

  // reference minus local, saturated to a signed tick value
  always_comb begin
    diff = {1'b0, reference_tick_i} - {1'b0, local_tick_i};
    if (diff[TICK_BITS] != diff[TICK_BITS-1]) begin
      sat = diff[TICK_BITS] ? {1'b1, {(TICK_BITS-1){1'b0}}}
                            : {1'b0, {(TICK_BITS-1){1'b1}}};
    end else begin
      sat = diff[TICK_BITS-1:0];
    end
    raw_d = {sat, {FRAC_BITS{1'b0}}};
  end

  assign ready_o = !vld_q || ready_i;
  assign vld_d   = ready_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      raw_q <= raw_d;
    end
  end

  assign valid_o = vld_q;
  assign raw_o   = raw_q;

endmodule

`default_nettype wire

// ===== rtl/core/cod_avg.sv =====
`default_nettype none

module cod_avg #(
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  cod_pkg::cfg_t                          cfg_i,
  input  wire                                    valid_i,
  output logic                                   ready_o,
  input  wire  [TICK_BITS+FRAC_BITS-1:0]         raw_i,
  output logic                                   valid_o,
  input  wire                                    ready_i,
  output logic signed [cod_pkg::CORR_W-1:0]      correction_o,
  output logic                                   correction_active_o,
  output logic signed [TICK_BITS+FRAC_BITS-1:0]  smoothed_offset_o
);

  import cod_pkg::*;

  localparam int W  = TICK_BITS + FRAC_BITS;
  localparam int CW = (W > DZ_W) ? W : DZ_W;
  localparam int PW = W + ALPHA_FRAC + 1;

  logic [W-1:0]          avg_d, avg_q;
  logic [COUNT_W-1:0]    cnt_d, cnt_q;
  logic                  first, alpha_one, active, warm, adv, out_vld_q;
  logic [W:0]            diff, dmag, step, sum;
  logic [PW-1:0]         prod, prod_r;
  logic [W-1:0]          mag;
  logic signed [CW:0]    avg_x, ms_x, lim;
  logic [CORR_W-1:0]     corr_d, corr_q;
  logic                  active_q;
  logic [W-1:0]          offs_q;

  always_comb begin
    cnt_d     = (&cnt_q) ? cnt_q : cnt_q + COUNT_W'(1);
    first     = (cnt_q == '0);
    alpha_one = (cfg_i.alpha >= ALPHA_ONE);

    // blend: step = |d| * alpha rounded, applied with the sign of d
    diff   = {raw_i[W-1], raw_i} - {avg_q[W-1], avg_q};
    dmag   = diff[W] ? (~diff + (W+1)'(1)) : diff;
    prod   = PW'(dmag) * PW'(cfg_i.alpha[ALPHA_FRAC-1:0]);
    prod_r = prod + PW'(ROUND_HALF);
    step   = prod_r[PW-1:ALPHA_FRAC];
    sum    = diff[W] ? ({avg_q[W-1], avg_q} - step) : ({avg_q[W-1], avg_q} + step);

    avg_d  = (first || alpha_one) ? raw_i : sum[W-1:0];

    mag    = avg_d[W-1] ? (~avg_d + W'(1)) : avg_d;
    active = CW'(mag) > CW'(cfg_i.dead_zone);
    warm   = cnt_d < cfg_i.warmup;

    avg_x = {{(CW+1-W){avg_d[W-1]}}, avg_d};
    ms_x  = {{(CW+1-STEP_W){1'b0}}, cfg_i.max_step};
    if (avg_x > ms_x) begin
      lim = ms_x;
    end else if (avg_x < -ms_x) begin
      lim = -ms_x;
    end else begin
      lim = avg_x;
    end
    corr_d = (!active || warm) ? '0 : lim[CORR_W-1:0];
  end

  assign ready_o = !out_vld_q || ready_i;
  assign adv     = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      avg_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (ready_o) begin
        out_vld_q <= valid_i;
      end
      if (adv) begin
        avg_q <= avg_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      corr_q   <= corr_d;
      active_q <= active;
      offs_q   <= avg_d;
    end
  end

  assign valid_o             = out_vld_q;
  assign correction_o        = corr_q;
  assign correction_active_o = active_q;
  assign smoothed_offset_o   = offs_q;

endmodule

`default_nettype wire

// ===== rtl/core/cod_checker.sv =====
`default_nettype none

module cod_checker #(
  parameter int OFFS_W = 48
) (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_o,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire [cod_pkg::CORR_W-1:0]  correction_o,
  input wire                        correction_active_o,
  input wire [OFFS_W-1:0]           smoothed_offset_o
);

  import cod_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(correction_o) && $stable(correction_active_o) && $stable(smoothed_offset_o))
    else $error("result payload changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without an input request two cycles before");

  a_corr_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (correction_o != '0) |->
      correction_active_o && (correction_o[CORR_W-1] == smoothed_offset_o[OFFS_W-1]))
    else $error("correction given while inactive or with wrong sign");

endmodule

bind clock_offset_drift_corrector cod_checker #(
  .OFFS_W (TICK_BITS + FRAC_BITS)
) u_cod_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .correction_o        (correction_o),
  .correction_active_o (correction_active_o),
  .smoothed_offset_o   (smoothed_offset_o)
);

`default_nettype wire
